@@ hdl/partial_shuffle_sampler_macros.svh @@
// Assertion macros shared by the partial shuffle sampler RTL.
// Depends on nothing; the user module must provide clk and arst_n.
`ifndef PARTIAL_SHUFFLE_SAMPLER_MACROS_SVH
`define PARTIAL_SHUFFLE_SAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/pss_pkg.sv @@
// Types and constants of the partial shuffle sampler.
// Used by the top level; depends on nothing.
package pss_pkg;

	localparam int CNT_W         = 11;
	localparam int IDX_W         = 10;
	localparam int EPOCH_W       = 8;
	localparam int MAX_ITEMS_DEF = 1024;
	localparam int REG_IDX_W     = 1;

	localparam logic [REG_IDX_W-1:0] REG_TOTAL_COUNT  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_SELECT_COUNT = 1'b1;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_DRAW  = 1'b1
	} func_t;

	typedef enum logic {
		ST_CLEAR = 1'b0,
		ST_RUN   = 1'b1
	} state_t;

	typedef struct packed {
		func_t            func;
		logic [IDX_W-1:0] swap_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] selected_index;
		logic             last;
		logic             error;
	} rsp_t;

endpackage

@@ hdl/pss_perm_ram.sv @@
// Permutation table storage: two registered read ports, one write port.
// Depends on nothing; instantiated by partial_shuffle_sampler.
module pss_perm_ram #(
	parameter int DEPTH = 1024,
	parameter int DW    = 18
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [DW-1:0]            rdata_a,
	output logic [DW-1:0]            rdata_b
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ hdl/partial_shuffle_sampler.sv @@
// Partial Fisher-Yates sampler: draws k of n indices without replacement.
// Depends on pss_pkg, pss_perm_ram and partial_shuffle_sampler_macros.svh.
//
//  channel  direction  handshake                 payload
//  cfg      in         cfg_wr_en                 cfg_index, cfg_data
//  req      in         req_valid / req_stall     pss_pkg::req_t (func, swap_index)
//  rsp      out        rsp_valid / rsp_stall     pss_pkg::rsp_t (selected_index, last, error)
//
// The block takes no new item while acc_s1 is set: the accept cycle reads entries i
// and j, the next cycle writes entry i and registers the result, and entry j is written
// while the next item is read, with forwarding. The single write port of the table
// sets this pace. After reset, and after every 255th start, a clearing pass writes
// every table entry while req_stall is high. Results wait in a two-entry buffer, and
// req_stall also rises while both entries are full.
`include "partial_shuffle_sampler_macros.svh"

module partial_shuffle_sampler #(
	parameter int MAX_ITEMS = pss_pkg::MAX_ITEMS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [pss_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [pss_pkg::CNT_W-1:0]      cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  pss_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output pss_pkg::rsp_t                  rsp
);

	localparam int CW = pss_pkg::CNT_W;
	localparam int EW = pss_pkg::EPOCH_W;
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int DW = EW + AW;
	localparam logic [CW-1:0] N_CAP =
		(MAX_ITEMS >= (1 << CW)) ? {CW{1'b1}} : CW'(MAX_ITEMS);
	localparam logic [AW-1:0] LAST_ADDR   = AW'(MAX_ITEMS - 1);
	localparam logic [EW-1:0] EPOCH_LAST  = {EW{1'b1}};
	localparam logic [EW-1:0] EPOCH_FIRST = EW'(1);

	pss_pkg::state_t state_q, state_nx;
	logic            clearing;
	logic            run_ready;

	logic [CW-1:0] total_q, select_q;
	logic [CW-1:0] position_q, draws_left_q;
	logic [EW-1:0] epoch_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_done;

	logic          req_accept;
	logic          is_draw;
	logic          draw_ok;
	logic          start_acc;
	logic          draw_acc;
	logic [CW-1:0] n_eff, k_eff;

	logic          acc_s1, draw_s1, ok_s1, last_s1;
	logic [AW-1:0] pa_s1, pb_s1;
	logic          wj_valid_s2;
	logic [AW-1:0] wj_addr_s2, wj_data_s2;
	logic          lw_valid_q;
	logic [AW-1:0] lw_addr_q;
	logic [DW-1:0] lw_data_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic [DW-1:0] rdata_a, rdata_b;
	logic [DW-1:0] word_a, word_b;
	logic [AW-1:0] val_a, val_b;

	pss_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;
	pss_pkg::rsp_t skid_q;
	logic          skid_valid_q;
	pss_pkg::rsp_t new_rsp;
	logic          rsp_take;

	assign clr_done = clr_addr_q == LAST_ADDR;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pss_pkg::ST_CLEAR: begin
				if (clr_done) begin
					state_nx = pss_pkg::ST_RUN;
				end
			end
			pss_pkg::ST_RUN: begin
				if (start_acc && epoch_q == EPOCH_LAST) begin
					state_nx = pss_pkg::ST_CLEAR;
				end
			end
		endcase
	end

	always_comb begin
		clearing  = 1'b0;
		run_ready = 1'b0;
		unique case (state_q)
			pss_pkg::ST_CLEAR: clearing  = 1'b1;
			pss_pkg::ST_RUN:   run_ready = 1'b1;
		endcase
	end

	assign rsp_take   = rsp_valid_q && !rsp_stall;
	assign req_stall  = !run_ready || acc_s1 || skid_valid_q;
	assign req_accept = req_valid && !req_stall;
	assign is_draw    = req.func == pss_pkg::FUNC_DRAW;
	assign draw_ok    = (draws_left_q != '0) && (CW'(req.swap_index) <= position_q);
	assign start_acc  = req_accept && !is_draw;
	assign draw_acc   = req_accept && is_draw;
	assign n_eff      = (total_q > N_CAP) ? N_CAP : total_q;
	assign k_eff      = (select_q > n_eff) ? n_eff : select_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pss_pkg::ST_CLEAR;
			clr_addr_q   <= '0;
			epoch_q      <= EPOCH_FIRST;
			total_q      <= '0;
			select_q     <= '0;
			position_q   <= '0;
			draws_left_q <= '0;
		end else begin
			state_q <= state_nx;
			if (clearing) begin
				clr_addr_q <= clr_done ? '0 : clr_addr_q + AW'(1);
				if (clr_done) begin
					epoch_q <= EPOCH_FIRST;
				end
			end else if (start_acc && epoch_q != EPOCH_LAST) begin
				epoch_q <= epoch_q + EW'(1);
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					pss_pkg::REG_TOTAL_COUNT:  total_q  <= cfg_data;
					pss_pkg::REG_SELECT_COUNT: select_q <= cfg_data;
				endcase
			end
			if (start_acc) begin
				position_q   <= (n_eff == '0) ? '0 : n_eff - CW'(1);
				draws_left_q <= k_eff;
			end else if (draw_acc && draw_ok) begin
				position_q   <= (position_q == '0) ? '0 : position_q - CW'(1);
				draws_left_q <= draws_left_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1       <= 1'b0;
			draw_s1      <= 1'b0;
			ok_s1        <= 1'b0;
			wj_valid_s2  <= 1'b0;
			lw_valid_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			acc_s1      <= req_accept;
			draw_s1     <= draw_acc;
			ok_s1       <= draw_acc && draw_ok;
			wj_valid_s2 <= ok_s1;
			lw_valid_q  <= mem_we;
			if (!rsp_valid_q || rsp_take) begin
				rsp_valid_q  <= skid_valid_q || draw_s1;
				skid_valid_q <= skid_valid_q && draw_s1;
			end else if (draw_s1) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_comb begin
		if (ok_s1) begin
			new_rsp = '{selected_index: pss_pkg::IDX_W'(val_b), last: last_s1, error: 1'b0};
		end else begin
			new_rsp = '{selected_index: '0, last: 1'b0, error: 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			last_s1 <= draws_left_q == CW'(1);
			pa_s1   <= AW'(position_q);
			pb_s1   <= AW'(req.swap_index);
		end
		if (ok_s1) begin
			wj_addr_s2 <= pb_s1;
			wj_data_s2 <= val_a;
		end
		lw_addr_q <= mem_waddr;
		lw_data_q <= mem_wdata;
		if (!rsp_valid_q || rsp_take) begin
			if (skid_valid_q) begin
				rsp_q <= skid_q;
			end else if (draw_s1) begin
				rsp_q <= new_rsp;
			end
		end
		if (draw_s1) begin
			skid_q <= new_rsp;
		end
	end

	// The table is read-old, so the entry written last cycle is taken from lw_*.
	assign word_a = (lw_valid_q && lw_addr_q == pa_s1) ? lw_data_q : rdata_a;
	assign word_b = (lw_valid_q && lw_addr_q == pb_s1) ? lw_data_q : rdata_b;
	assign val_a  = (word_a[DW-1 -: EW] == epoch_q) ? word_a[AW-1:0] : pa_s1;
	assign val_b  = (word_b[DW-1 -: EW] == epoch_q) ? word_b[AW-1:0] : pb_s1;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		priority if (clearing) begin
			mem_we = 1'b1;
		end else if (ok_s1) begin
			mem_we    = 1'b1;
			mem_waddr = pa_s1;
			mem_wdata = {epoch_q, val_b};
		end else if (wj_valid_s2) begin
			mem_we    = 1'b1;
			mem_waddr = wj_addr_s2;
			mem_wdata = {epoch_q, wj_data_s2};
		end
	end

	pss_perm_ram #(
		.DEPTH (MAX_ITEMS),
		.DW    (DW)
	) u_perm_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (req_accept),
		.raddr_a (AW'(position_q)),
		.raddr_b (AW'(req.swap_index)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PSS_ASSERT_SAME(a_two_cycle_cadence, acc_s1, !req_accept, "item accepted back to back")
	`PSS_ASSERT_SAME(a_rsp_slot_free, draw_s1, !skid_valid_q, "result buffer already full")
	`PSS_ASSERT_SAME(a_skid_behind_head, skid_valid_q, rsp_valid_q, "buffered result without head")
	`PSS_ASSERT_SAME(a_no_accept_clear, clearing, !req_accept, "item accepted during clearing")
	`PSS_ASSERT_SAME(a_one_writer, ok_s1, !wj_valid_s2 && !clearing, "write port conflict")

endmodule
